FILE: rtl/mcdv_pkg.sv
package mcdv_pkg;

	// Command codes carried in s_tuser
	localparam logic [1:0] CMD_POS   = 2'd0;
	localparam logic [1:0] CMD_SPEED = 2'd1;
	localparam logic [1:0] CMD_ACC   = 2'd2;
	localparam logic [1:0] CMD_RST   = 2'd3;

	// Motor direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	// Register file geometry
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned CFG_W  = 31;
	localparam int unsigned DATA_W = 32;

	// Register indexes
	localparam logic [2:0] REG_POS_LIMIT     = 3'd0;
	localparam logic [2:0] REG_SPD_FLOOR     = 3'd1;
	localparam logic [2:0] REG_SPD_LIMIT     = 3'd2;
	localparam logic [2:0] REG_STALL_BAND    = 3'd3;
	localparam logic [2:0] REG_ACC_LIMIT     = 3'd4;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd5;
	localparam logic [2:0] REG_SAMPLE_RATE   = 3'd6;
	localparam logic [2:0] REG_VOLTAGE_GAIN  = 3'd7;

	// Result packing
	localparam int unsigned RES_W = 40;

	typedef struct packed {
		logic [CFG_W-1:0] pos_limit;
		logic [CFG_W-1:0] spd_floor;
		logic [CFG_W-1:0] spd_limit;
		logic [CFG_W-1:0] stall_band;
		logic [CFG_W-1:0] acc_limit;
		logic [CFG_W-1:0] sample_period;
		logic [CFG_W-1:0] sample_rate;
		logic [CFG_W-1:0] voltage_gain;
	} cfg_t;

	// Datapath commands, one step each
	typedef struct packed {
		logic load;
		logic clamp;
		logic opnd;
		logic mul;
		logic scale;
		logic add;
		logic dir;
		logic vopnd;
		logic volt;
		logic push;
	} ctl_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       stop;
	} sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_OPND,
		ST_MUL1,
		ST_SCALE,
		ST_ADD,
		ST_DIR,
		ST_VOPND,
		ST_MUL2,
		ST_VOLT,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/mcdv_regs.sv
module mcdv_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mcdv_pkg::ADDR_W-1:0]   paddr,
	input  logic [mcdv_pkg::DATA_W-1:0]   pwdata,
	output logic [mcdv_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output mcdv_pkg::cfg_t                cfg
);
	import mcdv_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;
	logic [CFG_W-1:0] rd_val;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// Write one register per access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_limit     <= 31'h7FFF_FFFF;
			cfg_q.spd_floor     <= 31'd0;
			cfg_q.spd_limit     <= 31'd65536000;
			cfg_q.stall_band    <= 31'd0;
			cfg_q.acc_limit     <= 31'h7FFF_FFFF;
			cfg_q.sample_period <= 31'd66;
			cfg_q.sample_rate   <= 31'd65536000;
			cfg_q.voltage_gain  <= 31'd65536;
		end else if (wr_en) begin
			case (idx)
				REG_POS_LIMIT:     cfg_q.pos_limit     <= pwdata[CFG_W-1:0];
				REG_SPD_FLOOR:     cfg_q.spd_floor     <= pwdata[CFG_W-1:0];
				REG_SPD_LIMIT:     cfg_q.spd_limit     <= pwdata[CFG_W-1:0];
				REG_STALL_BAND:    cfg_q.stall_band    <= pwdata[CFG_W-1:0];
				REG_ACC_LIMIT:     cfg_q.acc_limit     <= pwdata[CFG_W-1:0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period <= pwdata[CFG_W-1:0];
				REG_SAMPLE_RATE:   cfg_q.sample_rate   <= pwdata[CFG_W-1:0];
				REG_VOLTAGE_GAIN:  cfg_q.voltage_gain  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_POS_LIMIT:     rd_val = cfg_q.pos_limit;
			REG_SPD_FLOOR:     rd_val = cfg_q.spd_floor;
			REG_SPD_LIMIT:     rd_val = cfg_q.spd_limit;
			REG_STALL_BAND:    rd_val = cfg_q.stall_band;
			REG_ACC_LIMIT:     rd_val = cfg_q.acc_limit;
			REG_SAMPLE_PERIOD: rd_val = cfg_q.sample_period;
			REG_SAMPLE_RATE:   rd_val = cfg_q.sample_rate;
			REG_VOLTAGE_GAIN:  rd_val = cfg_q.voltage_gain;
			default:           rd_val = '0;
		endcase
	end

	assign prdata = {1'b0, rd_val};

endmodule

FILE: rtl/mcdv_ctrl.sv
module mcdv_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  mcdv_pkg::sts_t sts,
	output mcdv_pkg::ctl_t ctl
);
	import mcdv_pkg::*;

	state_t state_q, state_d;
	logic   m_tvalid_q;

	assign m_tvalid = m_tvalid_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Sequence the datapath steps
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d  = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				ctl.clamp = 1'b1;
				case (sts.cmd)
					CMD_RST:   state_d = ST_DONE;
					CMD_SPEED: state_d = ST_DIR;
					default:   state_d = ST_OPND;
				endcase
			end
			ST_OPND: begin
				ctl.opnd = 1'b1;
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				ctl.mul = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				ctl.scale = 1'b1;
				state_d   = (sts.cmd == CMD_ACC) ? ST_ADD : ST_DIR;
			end
			ST_ADD: begin
				ctl.add = 1'b1;
				state_d = ST_DIR;
			end
			ST_DIR: begin
				ctl.dir = 1'b1;
				state_d = sts.stop ? ST_DONE : ST_VOPND;
			end
			ST_VOPND: begin
				ctl.vopnd = 1'b1;
				state_d   = ST_MUL2;
			end
			ST_MUL2: begin
				ctl.mul = 1'b1;
				state_d = ST_VOLT;
			end
			ST_VOLT: begin
				ctl.volt = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					ctl.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/mcdv_dpath.sv
module mcdv_dpath #(
	parameter logic [30:0] POS_FLOOR = 31'd0,
	parameter logic [30:0] ACC_FLOOR = 31'd0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mcdv_pkg::cfg_t               cfg,
	input  mcdv_pkg::ctl_t               ctl,
	output mcdv_pkg::sts_t               sts,
	input  logic [1:0]                   s_cmd,
	input  logic [31:0]                  s_setpoint,
	output logic [mcdv_pkg::RES_W-1:0]   result
);
	import mcdv_pkg::*;

	// Saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic ovf;
		ovf = (v[64:31] != {34{v[64]}});
		if (ovf) begin
			return v[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return v[31:0];
	endfunction

	// Clamp the magnitude to [lo, hi], keep the sign; zero counts as positive
	function automatic logic signed [31:0] clamp_mag(input logic signed [31:0] v,
			input logic [30:0] lo, input logic [30:0] hi);
		logic signed [32:0] ve;
		logic signed [32:0] m;
		logic signed [32:0] los;
		logic signed [32:0] his;
		logic signed [32:0] r;
		ve  = {v[31], v};
		m   = ve[32] ? -ve : ve;
		los = {2'b00, lo};
		his = {2'b00, hi};
		if (m < los) begin
			r = ve[32] ? -los : los;
		end else if (m > his) begin
			r = ve[32] ? -his : his;
		end else begin
			r = ve;
		end
		return r[31:0];
	endfunction

	// Item registers
	logic [1:0]         cmd_q;
	logic signed [31:0] sp_q;
	logic signed [31:0] clmp_q;
	logic signed [31:0] spd_q;
	logic signed [31:0] c_q;
	logic signed [32:0] mult_a_q;
	logic [30:0]        mult_b_q;
	logic               sh17_q;
	logic signed [64:0] prod_q;
	logic               dch_q;
	logic               vch_q;
	logic               stop_q;
	logic [RES_W-1:0]   res_q;

	// Motor state
	logic [1:0]         cur_dir_q;
	logic signed [31:0] volt_q;
	logic signed [31:0] last_pos_q;
	logic signed [31:0] last_spd_q;
	logic signed [31:0] last_acc_q;

	// Combinational terms
	logic signed [31:0] clmp_in;
	logic signed [64:0] scaled;
	logic signed [31:0] scaled_sat;
	logic signed [32:0] spd_sum;
	logic signed [31:0] spd_sum_sat;
	logic signed [32:0] spd_ext;
	logic signed [32:0] spd_mag;
	logic               is_stop;
	logic [1:0]         new_dir;
	logic signed [31:0] c_in;

	// Clamp position or acceleration setpoint
	assign clmp_in = (cmd_q == CMD_POS)
		? clamp_mag(sp_q, POS_FLOOR, cfg.pos_limit)
		: clamp_mag(sp_q, ACC_FLOOR, cfg.acc_limit);

	// Scale the product back to Q16.16, rounding toward minus infinity
	assign scaled     = sh17_q ? (prod_q >>> 17) : (prod_q >>> 16);
	assign scaled_sat = sat32(scaled);

	// Trapezoid step on top of the previous speed
	assign spd_sum     = {last_spd_q[31], last_spd_q} + {spd_q[31], spd_q};
	assign spd_sum_sat = sat32({{32{spd_sum[32]}}, spd_sum});

	// Direction with stall dead band, and speed magnitude clamp
	assign spd_ext = {spd_q[31], spd_q};
	assign spd_mag = spd_ext[32] ? -spd_ext : spd_ext;
	assign is_stop = spd_mag < $signed({2'b00, cfg.stall_band});
	assign new_dir = is_stop ? DIR_STOP
		: ((!spd_q[31] && (spd_q != '0)) ? DIR_FWD : DIR_BACK);
	assign c_in    = clamp_mag(spd_q, cfg.spd_floor, cfg.spd_limit);

	assign sts.cmd  = cmd_q;
	assign sts.stop = is_stop;
	assign result   = res_q;

	// Motor state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_dir_q  <= DIR_STOP;
			volt_q     <= '0;
			last_pos_q <= '0;
			last_spd_q <= '0;
			last_acc_q <= '0;
		end else begin
			if (ctl.clamp && (cmd_q == CMD_RST)) begin
				cur_dir_q  <= DIR_STOP;
				volt_q     <= '0;
				last_pos_q <= '0;
				last_spd_q <= '0;
				last_acc_q <= '0;
			end
			if (ctl.dir) begin
				cur_dir_q <= new_dir;
				case (cmd_q)
					CMD_POS: begin
						last_pos_q <= clmp_q;
						last_spd_q <= spd_q;
					end
					CMD_ACC: begin
						last_spd_q <= spd_q;
						last_acc_q <= clmp_q;
					end
					CMD_SPEED: begin
						if (!is_stop) begin
							last_spd_q <= c_in;
						end
					end
					default: ;
				endcase
			end
			if (ctl.volt) begin
				volt_q <= scaled_sat;
			end
		end
	end

	// Item payload steps
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= s_cmd;
			sp_q  <= s_setpoint;
		end
		if (ctl.clamp) begin
			clmp_q <= clmp_in;
			spd_q  <= sp_q;
			stop_q <= (cmd_q == CMD_RST);
			dch_q  <= (cur_dir_q != DIR_STOP);
			vch_q  <= 1'b0;
		end
		if (ctl.opnd) begin
			if (cmd_q == CMD_POS) begin
				mult_a_q <= {clmp_q[31], clmp_q} - {last_pos_q[31], last_pos_q};
				mult_b_q <= cfg.sample_rate;
				sh17_q   <= 1'b0;
			end else begin
				mult_a_q <= {clmp_q[31], clmp_q} + {last_acc_q[31], last_acc_q};
				mult_b_q <= cfg.sample_period;
				sh17_q   <= 1'b1;
			end
		end
		if (ctl.mul) begin
			prod_q <= $signed({{32{mult_a_q[32]}}, mult_a_q}) * $signed({34'd0, mult_b_q});
		end
		if (ctl.scale) begin
			spd_q <= scaled_sat;
		end
		if (ctl.add) begin
			spd_q <= spd_sum_sat;
		end
		if (ctl.dir) begin
			dch_q <= (new_dir != cur_dir_q);
			vch_q <= 1'b0;
			c_q   <= c_in;
		end
		if (ctl.vopnd) begin
			mult_a_q <= {c_q[31], c_q} - {2'b00, cfg.spd_floor};
			mult_b_q <= cfg.voltage_gain;
			sh17_q   <= 1'b0;
		end
		if (ctl.volt) begin
			vch_q <= (scaled_sat != volt_q);
		end
		if (ctl.push) begin
			res_q <= {3'b000, stop_q, vch_q, dch_q, volt_q, cur_dir_q};
		end
	end

endmodule

FILE: rtl/motor_command_to_drive_voltage_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = cmd, s_tdata = setpoint
// m_*       out  m_tvalid/m_tready  m_tdata = direction, drive_voltage, flags
// apb       in   psel/penable       eight 31-bit registers at 4*i
//
// One item at a time, one shared 33x31 multiplier used up to twice per item.
// Speed: CLAMP, DIR, VOPND, MUL2, VOLT, DONE; position adds OPND, MUL1 and
// SCALE, acceleration also ADD; reset CLAMP, DONE; the stall band skips the
// voltage steps. The next item is taken in the cycle after its result is
// loaded; a held result does not block it, the block stalls in DONE only
// when the previous result is not taken. Reset clears state, loads defaults.
module motor_command_to_drive_voltage_top #(
	parameter logic [30:0] POS_FLOOR = 31'd0,
	parameter logic [30:0] ACC_FLOOR = 31'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] setpoint
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] direction, [33:2] drive_voltage, [34] direction_changed,
	// [35] voltage_changed, [36] stop_pulse, [39:37] zero
	output logic [39:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mcdv_pkg::*;

	cfg_t cfg;
	ctl_t ctl;
	sts_t sts;

	// Configuration registers
	mcdv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Step sequencer and stream handshakes
	mcdv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Arithmetic and motor state
	mcdv_dpath #(
		.POS_FLOOR (POS_FLOOR),
		.ACC_FLOOR (ACC_FLOOR)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctl        (ctl),
		.sts        (sts),
		.s_cmd      (s_tuser),
		.s_setpoint (s_tdata),
		.result     (m_tdata)
	);

endmodule

FILE: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mcdv_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 24;
	localparam int REPORT_LIMIT = 10;
	localparam longint POS_FLOOR = 0;
	localparam longint ACC_FLOOR = 0;
	localparam longint Q16_MAX = 64'sd2147483647;
	localparam longint Q16_MIN = -64'sd2147483648;

	// Result fields, highest bit first, as they sit in m_tdata
	typedef struct packed {
		logic        stop_pulse;
		logic        voltage_changed;
		logic        direction_changed;
		logic [31:0] drive_voltage;
		logic [1:0]  direction;
	} drive_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] setpoint
	logic [1:0]  s_tuser;   // [1:0] cmd
	logic        m_tvalid;
	logic        m_tready;
	// [1:0] direction, [33:2] drive_voltage, [34] direction_changed,
	// [35] voltage_changed, [36] stop_pulse, [39:37] zero
	logic [39:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predicted register file and motor state
	logic [30:0]   cfg_reg [8];
	logic [1:0]    held_dir;
	int            held_volt;
	int            prev_pos;
	int            prev_spd;
	int            prev_acc;
	drive_result_t expected_drive_q [$];

	int mismatch_count;
	int result_count;
	bit tx_idle;
	bit rx_idle;
	bit hold_req;

	motor_command_to_drive_voltage_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint reg_val(logic [2:0] idx);
		longint v;
		v = 0;
		v[30:0] = cfg_reg[idx];
		return v;
	endfunction

	function automatic int sat_q16(longint v);
		if (v > Q16_MAX) return int'(Q16_MAX);
		if (v < Q16_MIN) return int'(Q16_MIN);
		return int'(v);
	endfunction

	// Exact product, floor shift, saturate
	function automatic int scale_floor(longint a, longint b, int unsigned shift);
		longint p;
		p = a * b;
		return sat_q16(p >>> shift);
	endfunction

	// Clamp magnitude into [lo, hi], keeping the sign; lower bound wins
	function automatic longint clamp_magnitude(longint v, longint lo, longint hi);
		longint m;
		m = (v < 0) ? -v : v;
		if (m < lo) return (v < 0) ? -lo : lo;
		if (m > hi) return (v < 0) ? -hi : hi;
		return v;
	endfunction

	// Speed to direction and voltage; dead band leaves voltage alone
	function automatic void drive_from_speed(int speed, bit keep_speed,
		output bit dch, output bit vch);
		longint s;
		longint m;
		longint c;
		logic [1:0] dir;
		int v;
		s = speed;
		m = (s < 0) ? -s : s;
		if (m < reg_val(REG_STALL_BAND)) dir = DIR_STOP;
		else if (s > 0) dir = DIR_FWD;
		else dir = DIR_BACK;
		dch = dir != held_dir;
		held_dir = dir;
		vch = 1'b0;
		if (dir == DIR_STOP) return;
		c = clamp_magnitude(s, reg_val(REG_SPD_FLOOR), reg_val(REG_SPD_LIMIT));
		v = scale_floor(c - reg_val(REG_SPD_FLOOR), reg_val(REG_VOLTAGE_GAIN), 16);
		vch = v != held_volt;
		held_volt = v;
		if (keep_speed) prev_spd = int'(c);
	endfunction

	function automatic drive_result_t predict_drive(logic [1:0] cmd, int setpoint);
		drive_result_t r;
		longint sp;
		longint pos;
		longint acc;
		int spd;
		int inc;
		bit dch;
		bit vch;
		sp = setpoint;
		dch = 1'b0;
		vch = 1'b0;
		r = '0;
		case (cmd)
			CMD_POS: begin
				pos = clamp_magnitude(sp, POS_FLOOR, reg_val(REG_POS_LIMIT));
				spd = scale_floor(pos - prev_pos, reg_val(REG_SAMPLE_RATE), 16);
				drive_from_speed(spd, 1'b0, dch, vch);
				prev_pos = int'(pos);
				prev_spd = spd;
			end
			CMD_SPEED: begin
				drive_from_speed(setpoint, 1'b1, dch, vch);
			end
			CMD_ACC: begin
				acc = clamp_magnitude(sp, ACC_FLOOR, reg_val(REG_ACC_LIMIT));
				inc = scale_floor(acc + prev_acc, reg_val(REG_SAMPLE_PERIOD), 17);
				spd = sat_q16(longint'(prev_spd) + inc);
				drive_from_speed(spd, 1'b0, dch, vch);
				prev_spd = spd;
				prev_acc = int'(acc);
			end
			CMD_RST: begin
				dch = held_dir != DIR_STOP;
				held_dir = DIR_STOP;
				held_volt = 0;
				prev_pos = 0;
				prev_spd = 0;
				prev_acc = 0;
				r.stop_pulse = 1'b1;
			end
		endcase
		r.direction = held_dir;
		r.drive_voltage = held_volt;
		r.direction_changed = dch;
		r.voltage_changed = vch;
		return r;
	endfunction

	// Random magnitude below 2^bits with a random sign
	function automatic int signed_mag(int unsigned bits);
		logic [31:0] mask;
		int v;
		mask = (32'h1 << bits) - 32'h1;
		v = int'($urandom & mask);
		return ($urandom_range(0, 1) != 0) ? -v : v;
	endfunction

	function automatic logic [31:0] rand_setpoint();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			1: return $urandom;
			default: return signed_mag($urandom_range(1, 31));
		endcase
	endfunction

	function automatic logic [31:0] pick_reg_value();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h1 << $urandom_range(4, 28));
		endcase
	endfunction

	// Predict each accepted item
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			expected_drive_q.push_back(predict_drive(s_tuser, s_tdata));
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		drive_result_t got;
		drive_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[36:0];
			result_count++;
			if (expected_drive_q.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("result %0d: no item pending, got dir %0d volt %h dch %b vch %b stop %b",
						result_count, got.direction, got.drive_voltage,
						got.direction_changed, got.voltage_changed, got.stop_pulse);
				mismatch_count++;
			end else begin
				want = expected_drive_q.pop_front();
				if (got.direction !== want.direction
					|| got.drive_voltage !== want.drive_voltage
					|| got.direction_changed !== want.direction_changed
					|| got.voltage_changed !== want.voltage_changed
					|| got.stop_pulse !== want.stop_pulse) begin
					if (mismatch_count < REPORT_LIMIT) begin
						$write("result %0d: expected dir %0d volt %h dch %b vch %b stop %b,",
							result_count, want.direction, want.drive_voltage,
							want.direction_changed, want.voltage_changed, want.stop_pulse);
						$display(" got dir %0d volt %h dch %b vch %b stop %b",
							got.direction, got.drive_voltage,
							got.direction_changed, got.voltage_changed, got.stop_pulse);
					end
					mismatch_count++;
				end
			end
		end
	end

	// Result side: random stalls, long hold-off on request
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (psel && penable && pready))
				quiet = 0;
			else
				quiet++;
		end
		$display("motor_command_to_drive_voltage_top: mismatch");
		$finish;
	end

	// Offer one item, with an optional idle burst first
	task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] setpoint);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= setpoint;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Drop valid and wait for every pending result
	task automatic drain_items();
		s_tvalid <= 1'b0;
		while (expected_drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		cfg_reg[idx] = value[30:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly runs of one command with drifting setpoints, some noise
	task automatic send_random_items(input int count);
		int sent;
		int len;
		int delta;
		logic [1:0] cmd;
		logic [31:0] base;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: begin
					case ($urandom_range(0, 2))
						0: cmd = CMD_POS;
						1: cmd = CMD_SPEED;
						default: cmd = CMD_ACC;
					endcase
					len = $urandom_range(4, 12);
					base = rand_setpoint();
					delta = signed_mag($urandom_range(2, 22));
					for (int j = 0; j < len; j++) begin
						send_cmd(cmd, base + j * delta);
						sent++;
					end
				end
				7: begin
					send_cmd(CMD_RST, $urandom);
					sent++;
				end
				default: begin
					send_cmd(2'($urandom_range(0, 3)), rand_setpoint());
					sent++;
				end
			endcase
		end
	endtask

	// Default registers: field extremes, zero speed, both reset cases
	task automatic test_directed_defaults();
		send_cmd(CMD_SPEED, 32'h0000_0000);
		send_cmd(CMD_SPEED, 32'h0001_0000);
		send_cmd(CMD_SPEED, 32'h7FFF_FFFF);
		send_cmd(CMD_SPEED, 32'h8000_0000);
		send_cmd(CMD_SPEED, 32'hFFFF_FFFF);
		send_cmd(CMD_RST, 32'h0000_0000);
		send_cmd(CMD_RST, 32'hFFFF_FFFF);
		send_cmd(CMD_POS, 32'h0000_0100);
		send_cmd(CMD_POS, 32'h7FFF_FFFF);
		send_cmd(CMD_POS, 32'h8000_0000);
		send_cmd(CMD_POS, 32'h0000_0000);
		send_cmd(CMD_ACC, 32'h7FFF_FFFF);
		send_cmd(CMD_ACC, 32'h8000_0000);
		send_cmd(CMD_ACC, 32'h0000_0000);
		drain_items();
	endtask

	// Dead band, lower bound above upper, zero sample terms
	task automatic test_directed_registers();
		write_reg(REG_POS_LIMIT, 32'h0003_0000);
		write_reg(REG_SPD_FLOOR, 32'h0014_0000);
		write_reg(REG_SPD_LIMIT, 32'h0005_0000);
		write_reg(REG_STALL_BAND, 32'h000A_0000);
		write_reg(REG_ACC_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_SAMPLE_PERIOD, 32'h0000_0000);
		write_reg(REG_SAMPLE_RATE, 32'h0000_0000);
		write_reg(REG_VOLTAGE_GAIN, 32'hFFFF_FFFF);
		send_cmd(CMD_SPEED, 32'h0064_0000);
		send_cmd(CMD_SPEED, 32'h0005_0000);
		send_cmd(CMD_SPEED, 32'hFFF1_0000);
		send_cmd(CMD_POS, 32'h0007_0000);
		send_cmd(CMD_ACC, 32'h0003_0000);
		send_cmd(CMD_RST, 32'h1234_5678);
		drain_items();
	endtask

	// Several register settings, all-ones and all-zeros among them
	task automatic test_random_settings();
		logic [31:0] v;
		for (int phase = 0; phase < 8; phase++) begin
			tx_idle = phase != 5;
			rx_idle = phase != 6;
			if (phase == 2) begin
				write_reg(REG_POS_LIMIT, 32'h0100_0000);
				write_reg(REG_SPD_FLOOR, 32'h0001_0000);
				write_reg(REG_SPD_LIMIT, 32'h01F4_0000);
				write_reg(REG_STALL_BAND, 32'h0000_8000);
				write_reg(REG_ACC_LIMIT, 32'h0064_0000);
				write_reg(REG_SAMPLE_PERIOD, 32'h0000_0042);
				write_reg(REG_SAMPLE_RATE, 32'h03E8_0000);
				write_reg(REG_VOLTAGE_GAIN, 32'h0000_0625);
			end else begin
				for (int r = REG_POS_LIMIT; r <= REG_VOLTAGE_GAIN; r++) begin
					case (phase)
						0: v = 32'hFFFF_FFFF;
						1: v = 32'h0000_0000;
						default: v = pick_reg_value();
					endcase
					write_reg(3'(r), v);
				end
			end
			send_random_items(200);
			drain_items();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Hold the result side off while items keep coming
	task automatic test_receiver_holdoff();
		hold_req = 1'b1;
		send_random_items(30);
		drain_items();
	endtask

	// Pause the sender until every result is back, then resume
	task automatic test_sender_pause();
		send_random_items(20);
		drain_items();
		send_random_items(20);
		drain_items();
	endtask

	// Last stretch at full rate on both sides
	task automatic test_no_idling();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_random_items(160);
		drain_items();
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_POS;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		mismatch_count = 0;
		result_count = 0;
		// Register defaults and cleared motor state
		cfg_reg[REG_POS_LIMIT] = 31'h7FFF_FFFF;
		cfg_reg[REG_SPD_FLOOR] = 31'd0;
		cfg_reg[REG_SPD_LIMIT] = 31'd65536000;
		cfg_reg[REG_STALL_BAND] = 31'd0;
		cfg_reg[REG_ACC_LIMIT] = 31'h7FFF_FFFF;
		cfg_reg[REG_SAMPLE_PERIOD] = 31'd66;
		cfg_reg[REG_SAMPLE_RATE] = 31'd65536000;
		cfg_reg[REG_VOLTAGE_GAIN] = 31'd65536;
		held_dir = DIR_STOP;
		held_volt = 0;
		prev_pos = 0;
		prev_spd = 0;
		prev_acc = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_directed_registers();
		test_random_settings();
		test_receiver_holdoff();
		test_sender_pause();
		test_no_idling();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_drive_q.size() != 0) mismatch_count++;
		if (mismatch_count == 0)
			$display("motor_command_to_drive_voltage_top: match");
		else
			$display("motor_command_to_drive_voltage_top: mismatch");
		$finish;
	end

endmodule
